// ===== rtl/core/gbe_pkg.sv =====
// Shared types, constants and pixel arithmetic for the grayscale blit engine.
// No dependencies; used by grayscale_blit_engine_top and gbe_store.
package gbe_pkg;

	localparam int PIX_W       = 8;
	localparam int OPCODE_W    = 3;
	localparam int CW          = 17;   // signed working width for coordinates and sums
	localparam int REG_W       = 9;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [REG_W-1:0] REG_RESET_VAL = 9'd256;
	localparam logic             REG_IDX_WIDTH  = 1'b0;
	localparam logic             REG_IDX_HEIGHT = 1'b1;

	localparam logic [9:0] GRAY_SUM_MAX = 10'd765;
	localparam logic [9:0] DIV3_MUL     = 10'd683;  // 683 / 2048 is exact for 0..765
	localparam int         DIV3_SHIFT   = 11;
	localparam logic [7:0] PIX_MAX      = 8'd255;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR = 3'd0,
		OP_FILL  = 3'd1,
		OP_BLEND = 3'd2,
		OP_READ  = 3'd3,
		OP_LOAD  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		BM_COPY  = 2'd0,
		BM_ADD   = 2'd1,
		BM_SUB   = 2'd2,
		BM_ALPHA = 2'd3
	} blend_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FILL,
		S_BLEND_WR,
		S_READ_DATA,
		S_GRAY_MUL,
		S_GRAY_WR,
		S_DONE
	} state_t;

	// Command item as packed on s_tdata, first member in the top bits.
	typedef struct packed {
		logic [5:0]         rsvd;
		logic [7:0]         pixel_alpha;
		logic [7:0]         blue;
		logic [7:0]         green;
		logic [7:0]         red;
		logic [7:0]         blend_alpha;
		logic [1:0]         blend_mode;
		logic [7:0]         pixel_in;
		logic signed [15:0] coord_y1;
		logic signed [15:0] coord_x1;
		logic signed [15:0] coord_y0;
		logic signed [15:0] coord_x0;
	} cmd_t;

	localparam int IN_TDATA_W = $bits(cmd_t);

	// m / 255 for m <= 255*255: estimate m >> 8, remainder stays below 2*255.
	function automatic logic [7:0] div255(input logic [15:0] m);
		logic [7:0] t0;
		logic [8:0] rem;
		t0  = m[15:8];
		rem = {1'b0, m[7:0]} + {1'b0, t0};
		return t0 + 8'(rem >= 9'd255);
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? PIX_MAX : s[7:0];
	endfunction

	// f: stored pixel, p: source pixel, ap: blend_alpha * p
	function automatic logic [7:0] blend_px(input logic [7:0] f, input logic [7:0] p,
			input logic [1:0] mode, input logic [15:0] ap);
		logic [7:0] res;
		res = p;
		case (blend_mode_t'(mode))
			BM_COPY:  res = p;
			BM_ADD:   res = sat_add(f, p);
			BM_SUB:   res = (f > p) ? f - p : 8'd0;
			BM_ALPHA: res = sat_add(f, div255(ap) >> 2);
			default:  res = p;
		endcase
		return res;
	endfunction

endpackage

// ===== rtl/core/gbe_store.sv =====
// Frame store: one write port, one read port, registered read data.
// Depends on gbe_pkg for the pixel width.
module gbe_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [gbe_pkg::PIX_W-1:0]  wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [gbe_pkg::PIX_W-1:0]  rdata
);
	import gbe_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/grayscale_blit_engine_top.sv =====
// Grayscale blit engine top level: command decode, clipping, fill sequencer,
// read-modify-write blend, read and RGBA-to-gray load. Depends on gbe_pkg and gbe_store.
//
// Each item runs from accept through S_DECODE to S_DONE; a miss or unused opcode goes
//   straight there, read via S_READ_DATA, blend via S_BLEND_WR, RGBA load via S_GRAY_MUL
//   and S_GRAY_WR, clear/fill via S_FILL: one write port, so one pixel a cycle.
// S_DONE waits for a free output register; m_tvalid rises as the engine reenters S_IDLE.
// One item is in flight at a time; its result waits in the output register while the
// next item is taken. Reset clears control state and sets both size registers to 256;
// the frame store is not cleared and must be written (e.g. by a clear) before reads.
module grayscale_blit_engine_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gbe_pkg::APB_AW-1:0]          paddr,
	input  logic [gbe_pkg::APB_DW-1:0]          pwdata,
	output logic [gbe_pkg::APB_DW-1:0]          prdata,
	output logic                                pready,
	// command items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata, low bit up: coord_x0[15:0], coord_y0[31:16], coord_x1[47:32],
	// coord_y1[63:48], pixel_in[71:64], blend_mode[73:72], blend_alpha[81:74],
	// red[89:82], green[97:90], blue[105:98], pixel_alpha[113:106], zero pad[119:114]
	input  logic [gbe_pkg::IN_TDATA_W-1:0]      s_tdata,
	// s_tuser: opcode[2:0]
	input  logic [gbe_pkg::OPCODE_W-1:0]        s_tuser,
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: read_value[7:0]
	output logic [gbe_pkg::PIX_W-1:0]           m_tdata,
	// m_tuser: hit[0]
	output logic [0:0]                          m_tuser
);
	import gbe_pkg::*;

	localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [CW-1:0] W_LIM = CW'(MAX_WIDTH);
	localparam logic signed [CW-1:0] H_LIM = CW'(MAX_HEIGHT);

	// ---------------- configuration registers ----------------
	logic [REG_W-1:0] width_q, height_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= REG_RESET_VAL;
			height_q <= REG_RESET_VAL;
		end else if (cfg_wr) begin
			// low address bits are ignored; bit 2 picks the register
			case (paddr[2])
				REG_IDX_WIDTH:  width_q  <= pwdata[REG_W-1:0];
				REG_IDX_HEIGHT: height_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_IDX_HEIGHT) ? APB_DW'(height_q) : APB_DW'(width_q);

	// ---------------- state and command registers ----------------
	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [OPCODE_W-1:0] op_q;

	// fill sequencer
	logic [XW-1:0] cx_q, xf_q, xl_q;
	logic [YW-1:0] cy_q, yl_q;
	// per-pixel work
	logic [AW-1:0] tgt_addr_q;
	logic [15:0]   ap_q;        // blend_alpha * pixel_in
	logic [7:0]    gray_q3_q;   // (765 - sum) / 3
	logic [15:0]   gray_m_q;    // gray_q3_q * pixel_alpha
	logic          hit_q;
	logic [7:0]    rv_q;
	// output register
	logic          m_valid_q;
	logic [7:0]    m_rv_q;
	logic          m_hit_q;
	logic          out_free;

	// store port
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	// ---------------- decode: clipping and addressing ----------------
	logic signed [CW-1:0] w_reg, h_reg, eff_w, eff_h;
	logic signed [CW-1:0] rl, rt, rr, rb, cl, ct, cr, cb;
	logic signed [CW-1:0] pt_x, pt_y;
	logic                 is_clear, rect_ne, pt_hit, hit_d;
	logic [XW-1:0]        x_first, x_last;
	logic [YW-1:0]        y_first, y_last;
	logic [AW-1:0]        pt_addr, fill_addr;
	logic [9:0]           gray_sum, gray_diff;
	logic [19:0]          div3_prod;
	logic                 fill_last_col, fill_done;

	always_comb begin
		w_reg = $signed({{(CW-REG_W){1'b0}}, width_q});
		h_reg = $signed({{(CW-REG_W){1'b0}}, height_q});
		eff_w = (w_reg > W_LIM) ? W_LIM : w_reg;
		eff_h = (h_reg > H_LIM) ? H_LIM : h_reg;

		is_clear = (op_q == OP_CLEAR);
		rl = is_clear ? '0    : CW'(cmd_q.coord_x0);
		rt = is_clear ? '0    : CW'(cmd_q.coord_y0);
		rr = is_clear ? eff_w : CW'(cmd_q.coord_x1);
		rb = is_clear ? eff_h : CW'(cmd_q.coord_y1);
		cl = (rl < 0) ? '0 : rl;
		ct = (rt < 0) ? '0 : rt;
		cr = (rr > eff_w) ? eff_w : rr;
		cb = (rb > eff_h) ? eff_h : rb;
		rect_ne = (cl < cr) && (ct < cb);
		x_first = cl[XW-1:0];
		y_first = ct[YW-1:0];
		x_last  = XW'(cr - CW'(1));
		y_last  = YW'(cb - CW'(1));

		// blend targets the offset position, read and load the plain one
		if (op_q == OP_BLEND) begin
			pt_x = CW'(cmd_q.coord_x0) + CW'(cmd_q.coord_x1);
			pt_y = CW'(cmd_q.coord_y0) + CW'(cmd_q.coord_y1);
		end else begin
			pt_x = CW'(cmd_q.coord_x0);
			pt_y = CW'(cmd_q.coord_y0);
		end
		pt_hit = (pt_x >= 0) && (pt_y >= 0) && (pt_x < eff_w) && (pt_y < eff_h);

		unique case (op_q) inside
			OP_CLEAR, OP_FILL:         hit_d = rect_ne;
			OP_BLEND, OP_READ, OP_LOAD: hit_d = pt_hit;
			default:                    hit_d = 1'b0;
		endcase

		gray_sum  = 10'(cmd_q.red) + 10'(cmd_q.green) + 10'(cmd_q.blue);
		gray_diff = GRAY_SUM_MAX - gray_sum;
		div3_prod = 20'(gray_diff) * 20'(DIV3_MUL);
	end

	assign pt_addr   = AW'(pt_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(pt_x[XW-1:0]);
	assign fill_addr = AW'(cy_q) * AW'(MAX_WIDTH) + AW'(cx_q);

	assign fill_last_col = (cx_q == xl_q);
	assign fill_done     = fill_last_col && (cy_q == yl_q);
	assign out_free      = !m_valid_q || m_tready;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tgt_addr_q;
		mem_wdata = cmd_q.pixel_in;
		mem_re    = 1'b0;
		mem_raddr = pt_addr;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (op_q) inside
					OP_CLEAR, OP_FILL: begin
						if (rect_ne) begin
							state_d = S_FILL;
						end
					end
					OP_BLEND: begin
						if (pt_hit) begin
							mem_re  = 1'b1;
							state_d = S_BLEND_WR;
						end
					end
					OP_READ: begin
						if (pt_hit) begin
							mem_re  = 1'b1;
							state_d = S_READ_DATA;
						end
					end
					OP_LOAD: begin
						if (pt_hit) begin
							state_d = S_GRAY_MUL;
						end
					end
					default: ;
				endcase
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_addr;
				if (fill_done) begin
					state_d = S_DONE;
				end
			end
			S_BLEND_WR: begin
				// read data of the target arrived; write back the blended pixel.
				// One item at a time, so no later access can overlap this entry.
				mem_we    = 1'b1;
				mem_wdata = blend_px(mem_rdata, cmd_q.pixel_in, cmd_q.blend_mode, ap_q);
				state_d   = S_DONE;
			end
			S_READ_DATA: state_d = S_DONE;
			S_GRAY_MUL:  state_d = S_GRAY_WR;
			S_GRAY_WR: begin
				mem_we    = 1'b1;
				mem_wdata = div255(gray_m_q);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_t'(s_tdata);
			op_q  <= s_tuser;
		end
		case (state_q)
			S_DECODE: begin
				cx_q       <= x_first;
				cy_q       <= y_first;
				xf_q       <= x_first;
				xl_q       <= x_last;
				yl_q       <= y_last;
				tgt_addr_q <= pt_addr;
				ap_q       <= 16'(cmd_q.blend_alpha) * 16'(cmd_q.pixel_in);
				gray_q3_q  <= 8'(div3_prod >> DIV3_SHIFT);
				hit_q      <= hit_d;
				rv_q       <= '0;
			end
			S_FILL: begin
				// raster order over the clipped rectangle
				if (fill_last_col) begin
					cx_q <= xf_q;
					cy_q <= cy_q + YW'(1);
				end else begin
					cx_q <= cx_q + XW'(1);
				end
			end
			S_READ_DATA: rv_q     <= mem_rdata;
			S_GRAY_MUL:  gray_m_q <= 16'(gray_q3_q) * 16'(cmd_q.pixel_alpha);
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			m_rv_q  <= rv_q;
			m_hit_q <= hit_q;
		end
	end

	// output register: the finished result waits here while the next item comes in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_rv_q;
	assign m_tuser[0] = m_hit_q;

	gbe_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef NO_ASSERTIONS
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_FILL || state_q == S_BLEND_WR || state_q == S_GRAY_WR))
		else $error("store written outside a write state");

	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> (cx_q >= xf_q && cx_q <= xl_q && cy_q <= yl_q))
		else $error("fill counters left the clipped rectangle");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_DECODE)
		else $error("accepted item not decoded");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("read value nonzero without hit");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> m_tvalid && state_q == S_IDLE)
		else $error("result not loaded into output register");
`endif

endmodule
